[hw/rtl/rrd_pkg.sv]
// ----------------------------------------------------------------------------
// rrd_pkg
// Shared types, sizes and codes for the round-robin time-slice dispatcher.
// ----------------------------------------------------------------------------
package rrd_pkg;

   // queue depth and the widths that follow from it
   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // fixed field widths
   localparam int ID_W     = 8;
   localparam int BURST_W  = 16;
   localparam int SLICE_W  = 16;
   localparam int QUEUED_W = 5;
   localparam int TOTAL_W  = 32;
   localparam int PROD_W   = SLICE_W + CNT_W;

   localparam logic [SLICE_W-1:0] SLICE_RESET = SLICE_W'(10);

   typedef logic [PTR_W-1:0]   ptr_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [ID_W-1:0]    id_type;
   typedef logic [BURST_W-1:0] burst_type;
   typedef logic [TOTAL_W-1:0] total_type;

   typedef enum logic {
      OP_ADD      = 1'b0,
      OP_DISPATCH = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_ADDED      = 2'd0,
      ST_REFUSED    = 2'd1,
      ST_DISPATCHED = 2'd2,
      ST_IDLE       = 2'd3
   } status_type;

   // circular pointer advance, wraps at the queue depth
   function automatic ptr_type next_slot(input ptr_type p);
      ptr_type r;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

endpackage

[hw/rtl/round_robin_dispatcher.sv]
// ----------------------------------------------------------------------------
// round_robin_dispatcher
// Round-robin time-slice dispatcher: a FIFO of process ids with remaining
// burst, one add or one dispatch per transaction, saturating busy and wait
// totals.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                    payload
//   req_      in         req_valid / req_stall        opcode, process_id, burst_length
//   rsp_      out        rsp_valid / rsp_stall        status, run_id, slice_used,
//                                                     finished, queued, totals
//   csr_      in         csr_wr_en                    slice_length
//
// A transaction is registered on acceptance and resolved once the result
// register can take it; the queue, pointers and totals then update and the
// result register loads. One transaction per cycle is sustained while the
// result is not stalled, set by the single queue update per cycle.
// Synchronous reset empties the queue, clears both totals and sets the slice
// to 10. A stalled result holds the block; req_stall rises only when the
// input register is full and cannot move into the result register.
//
module round_robin_dispatcher
   import rrd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_opcode,
   input  logic [ID_W-1:0]       req_process_id,
   input  logic [BURST_W-1:0]    req_burst_length,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_status,
   output logic [ID_W-1:0]       rsp_run_id,
   output logic [SLICE_W-1:0]    rsp_slice_used,
   output logic                  rsp_finished,
   output logic [QUEUED_W-1:0]   rsp_queued,
   output logic [TOTAL_W-1:0]    rsp_busy_total,
   output logic [TOTAL_W-1:0]    rsp_wait_total,
   // configuration
   input  logic                  csr_wr_en,
   input  logic [SLICE_W-1:0]    csr_wr_data
);

   // queue storage, one write per transaction
   id_type        id_store_ff        [QUEUE_DEPTH];
   burst_type     remaining_store_ff [QUEUE_DEPTH];

   // control state
   ptr_type       head_ptr_ff, head_ptr_in;
   ptr_type       tail_ptr_ff, tail_ptr_in;
   cnt_type       entry_count_ff, entry_count_in;
   total_type     busy_sum_ff, busy_sum_in;
   total_type     wait_sum_ff, wait_sum_in;
   logic [SLICE_W-1:0] slice_ff;

   // input register
   logic          item_valid_ff, item_valid_in;
   opcode_type    item_opcode_ff;
   id_type        item_id_ff;
   burst_type     item_burst_ff;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    status_ff, status_in;
   id_type        run_id_ff, run_id_in;
   logic [SLICE_W-1:0] used_ff, used_in;
   logic          finished_ff, finished_in;

   // queue write port
   logic          wr_en;
   ptr_type       wr_ptr;
   id_type        wr_id;
   burst_type     wr_rem;

   logic          req_take;
   logic          proc_fire;

   // handshake
   assign proc_fire = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && !proc_fire;
   assign req_take  = req_valid && !req_stall;

   assign item_valid_in = req_take ? 1'b1 : (proc_fire ? 1'b0 : item_valid_ff);
   assign rsp_valid_in  = proc_fire ? 1'b1 : (rsp_valid_ff && rsp_stall);

   // transaction resolve
   always_comb begin
      burst_type           head_rem;
      logic [SLICE_W-1:0]  slice_eff;
      logic [SLICE_W-1:0]  used;
      burst_type           rem_left;
      cnt_type             others;
      logic [PROD_W-1:0]   wait_add;
      logic [TOTAL_W:0]    busy_sum_wide;
      logic [TOTAL_W:0]    wait_sum_wide;

      head_ptr_in    = head_ptr_ff;
      tail_ptr_in    = tail_ptr_ff;
      entry_count_in = entry_count_ff;
      busy_sum_in    = busy_sum_ff;
      wait_sum_in    = wait_sum_ff;
      status_in      = status_ff;
      run_id_in      = run_id_ff;
      used_in        = used_ff;
      finished_in    = finished_ff;
      wr_en          = 1'b0;
      wr_ptr         = tail_ptr_ff;
      wr_id          = item_id_ff;
      wr_rem         = item_burst_ff;

      head_rem      = remaining_store_ff[head_ptr_ff];
      slice_eff     = (slice_ff == '0) ? SLICE_W'(1) : slice_ff;
      used          = (head_rem < slice_eff) ? head_rem : slice_eff;
      rem_left      = head_rem - used;
      others        = entry_count_ff - CNT_W'(1);
      wait_add      = PROD_W'(used) * PROD_W'(others);
      busy_sum_wide = {1'b0, busy_sum_ff} + (TOTAL_W+1)'(used);
      wait_sum_wide = {1'b0, wait_sum_ff} + (TOTAL_W+1)'(wait_add);

      if (proc_fire) begin
         run_id_in   = '0;
         used_in     = '0;
         finished_in = 1'b0;
         unique case (item_opcode_ff)
            OP_ADD: begin
               if (entry_count_ff == CNT_W'(QUEUE_DEPTH)) begin
                  status_in = ST_REFUSED;
               end else begin
                  wr_en          = 1'b1;
                  tail_ptr_in    = next_slot(tail_ptr_ff);
                  entry_count_in = entry_count_ff + CNT_W'(1);
                  status_in      = ST_ADDED;
               end
            end
            OP_DISPATCH: begin
               if (entry_count_ff == '0) begin
                  status_in = ST_IDLE;
               end else begin
                  status_in   = ST_DISPATCHED;
                  run_id_in   = id_store_ff[head_ptr_ff];
                  used_in     = used;
                  head_ptr_in = next_slot(head_ptr_ff);
                  // requeue at the tail while work remains
                  if (rem_left != '0) begin
                     wr_en       = 1'b1;
                     wr_id       = id_store_ff[head_ptr_ff];
                     wr_rem      = rem_left;
                     tail_ptr_in = next_slot(tail_ptr_ff);
                  end else begin
                     entry_count_in = others;
                     finished_in    = 1'b1;
                  end
                  // saturating totals
                  busy_sum_in = busy_sum_wide[TOTAL_W] ? '1 : busy_sum_wide[TOTAL_W-1:0];
                  wait_sum_in = wait_sum_wide[TOTAL_W] ? '1 : wait_sum_wide[TOTAL_W-1:0];
               end
            end
            default: begin
               status_in = status_ff;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         head_ptr_ff    <= '0;
         tail_ptr_ff    <= '0;
         entry_count_ff <= '0;
         busy_sum_ff    <= '0;
         wait_sum_ff    <= '0;
         slice_ff       <= SLICE_RESET;
      end else begin
         item_valid_ff  <= item_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         head_ptr_ff    <= head_ptr_in;
         tail_ptr_ff    <= tail_ptr_in;
         entry_count_ff <= entry_count_in;
         busy_sum_ff    <= busy_sum_in;
         wait_sum_ff    <= wait_sum_in;
         if (csr_wr_en) begin
            slice_ff <= csr_wr_data;
         end
      end
   end

   // payload registers and queue storage
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_opcode_ff <= opcode_type'(req_opcode);
         item_id_ff     <= req_process_id;
         item_burst_ff  <= req_burst_length;
      end
      status_ff   <= status_in;
      run_id_ff   <= run_id_in;
      used_ff     <= used_in;
      finished_ff <= finished_in;
      if (wr_en) begin
         id_store_ff[wr_ptr]        <= wr_id;
         remaining_store_ff[wr_ptr] <= wr_rem;
      end
   end

   // result outputs, totals and fill level track the result register
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_run_id     = run_id_ff;
   assign rsp_slice_used = used_ff;
   assign rsp_finished   = finished_ff;
   assign rsp_queued     = QUEUED_W'(entry_count_ff);
   assign rsp_busy_total = busy_sum_ff;
   assign rsp_wait_total = wait_sum_ff;

endmodule

[hw/rtl/rrd_checker.sv]
// ----------------------------------------------------------------------------
// rrd_checker
// Port-level checks for the round-robin dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
module rrd_checker
   import rrd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [1:0]            rsp_status,
   input  logic [ID_W-1:0]       rsp_run_id,
   input  logic [SLICE_W-1:0]    rsp_slice_used,
   input  logic                  rsp_finished,
   input  logic [QUEUED_W-1:0]   rsp_queued,
   input  logic [TOTAL_W-1:0]    rsp_busy_total,
   input  logic [TOTAL_W-1:0]    rsp_wait_total
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_busy_total) && $stable(rsp_wait_total))
      else $error("stalled result changed");

   // only a dispatch carries run fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_DISPATCHED) |->
         (rsp_run_id == '0) && (rsp_slice_used == '0) && !rsp_finished)
      else $error("run fields set without dispatch");

   // a requeued process always ran for at least one unit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_DISPATCHED) && !rsp_finished |->
         (rsp_slice_used != '0) && (rsp_queued != '0))
      else $error("requeue without progress");

   // refusal only when full, idle only when empty
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_REFUSED) |->
         rsp_queued == QUEUED_W'(QUEUE_DEPTH))
      else $error("refused while not full");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_IDLE) |-> rsp_queued == '0)
      else $error("idle while queue holds entries");

endmodule

bind round_robin_dispatcher rrd_checker u_rrd_checker (.*);
